// ----- rtl/hkpf_pkg.sv -----
// hkpf_pkg: types and fixed constants of the hashed key presence filter
// no dependencies; used by hashed_key_presence_filter by scoped names

package hkpf_pkg;

    // control states of the filter
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REPLY
    } hkpf_state_t;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_BITS = 8'd1;

    // register widths and reset values
    localparam int KEY_LENGTH_W = 8;
    localparam int TABLE_BITS_W = 5;

    localparam logic [KEY_LENGTH_W-1:0] KEY_LENGTH_RESET = 8'd4;
    localparam logic [TABLE_BITS_W-1:0] TABLE_BITS_RESET = 5'd10;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // hash constants
    localparam int SEED_VALUE  = 50;
    localparam int LEFT_SHIFT  = 6;
    localparam int RIGHT_SHIFT = 2;

    // log2 of the widest occupancy row
    localparam int ROW_LOG_MAX = 5;

    localparam int SLOT_INDEX_W = 16;

endpackage

// ----- rtl/hashed_key_presence_filter.sv -----
// hashed_key_presence_filter: running shift-add-xor hash over key bytes and
// a one-bit occupancy map held in a synchronous memory
// depends on hkpf_pkg
//
// usage
//   input: one key byte per transfer, taken at a clock edge with start high
//   and busy low. req_type is looked at only with the last byte of a key.
//   a byte that does not end a key leaves busy low; the next may follow at
//   once. the last byte of a key starts a row read of the occupancy memory,
//   and the result comes out in the following cycle, during which busy is
//   high.
//   output: result_valid is high for exactly one cycle with slot_index,
//   slot_occupied and was_insert; the receiver cannot stall it.
//   configuration: cfg_ready is always high; register 0 is key_length,
//   register 1 is table_bits, other indexes are dropped. write only when
//   idle.
//   reset: the occupancy memory is cleared one row per cycle; busy stays
//   high throughout, and configuration writes are still taken.

module hashed_key_presence_filter #(
    parameter int MAX_TABLE_BITS = 16,
    parameter int HASH_WIDTH     = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [7:0]                           data_byte,

    output logic                                 result_valid,
    output logic [hkpf_pkg::SLOT_INDEX_W-1:0]    slot_index,
    output logic                                 slot_occupied,
    output logic                                 was_insert,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hkpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hkpf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ROW_LOG = (MAX_TABLE_BITS > hkpf_pkg::ROW_LOG_MAX) ?
                             hkpf_pkg::ROW_LOG_MAX : MAX_TABLE_BITS - 1;
    localparam int ROW_W   = 1 << ROW_LOG;
    localparam int BIT_W   = (ROW_LOG > 0) ? ROW_LOG : 1;
    localparam int ADDR_W  = MAX_TABLE_BITS - ROW_LOG;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int EXT_W   = (HASH_WIDTH > MAX_TABLE_BITS) ? HASH_WIDTH : MAX_TABLE_BITS;

    localparam logic [HASH_WIDTH-1:0] SEED = HASH_WIDTH'(hkpf_pkg::SEED_VALUE);

    hkpf_pkg::hkpf_state_t state_reg, state_next;

    logic [hkpf_pkg::KEY_LENGTH_W-1:0] key_length_reg;
    logic [hkpf_pkg::TABLE_BITS_W-1:0] table_bits_reg;

    logic [HASH_WIDTH-1:0]     hash_reg;
    logic [HASH_WIDTH-1:0]     hash_next;
    logic [7:0]                bytes_seen_reg;
    logic [7:0]                bytes_seen_next;
    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic [MAX_TABLE_BITS-1:0] slot_reg;
    logic                      req_reg;

    logic                      accept;
    logic                      key_done;
    logic [HASH_WIDTH-1:0]     mix;
    logic [HASH_WIDTH-1:0]     hash_new;
    logic [EXT_W-1:0]          hash_ext;
    logic [7:0]                need;
    logic [8:0]                count;
    logic                      key_final;
    logic [hkpf_pkg::TABLE_BITS_W-1:0] active_bits;
    logic [MAX_TABLE_BITS-1:0] slot_mask;
    logic [MAX_TABLE_BITS-1:0] slot_new;
    logic [BIT_W-1:0]          bit_sel;

    // occupancy memory, one row of ROW_W slots per entry
    logic [ROW_W-1:0]          occ_mem [DEPTH];
    logic [ROW_W-1:0]          rd_data_reg;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ROW_W-1:0]          wr_data;

    assign accept    = start & ~busy;
    assign cfg_ready = 1'b1;

    // hash step and key completion
    always_comb
    begin
        mix       = (hash_reg << hkpf_pkg::LEFT_SHIFT) + (hash_reg >> hkpf_pkg::RIGHT_SHIFT)
                    + HASH_WIDTH'(data_byte);
        hash_new  = hash_reg ^ mix;
        hash_ext  = EXT_W'(hash_new);
        need      = (key_length_reg == 8'd0) ? 8'd1 : key_length_reg;
        count     = {1'b0, bytes_seen_reg} + 9'd1;
        key_final = (count >= {1'b0, need});
        if (table_bits_reg > hkpf_pkg::TABLE_BITS_W'(MAX_TABLE_BITS))
        begin
            active_bits = hkpf_pkg::TABLE_BITS_W'(MAX_TABLE_BITS);
        end
        else
        begin
            active_bits = table_bits_reg;
        end
        slot_mask = ~({MAX_TABLE_BITS{1'b1}} << active_bits);
        slot_new  = hash_ext[MAX_TABLE_BITS-1:0] & slot_mask;
    end

    assign key_done = accept & key_final;
    assign bit_sel  = BIT_W'(slot_reg % ROW_W);

    always_comb
    begin
        if (key_done)
        begin
            hash_next       = SEED;
            bytes_seen_next = 8'd0;
        end
        else if (accept)
        begin
            hash_next       = hash_new;
            bytes_seen_next = count[7:0];
        end
        else
        begin
            hash_next       = hash_reg;
            bytes_seen_next = bytes_seen_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hkpf_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    state_next = hkpf_pkg::ST_IDLE;
                end
            end
            hkpf_pkg::ST_IDLE:
            begin
                if (key_done)
                begin
                    state_next = hkpf_pkg::ST_REPLY;
                end
            end
            hkpf_pkg::ST_REPLY:
            begin
                state_next = hkpf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hkpf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and memory control
    always_comb
    begin
        busy         = 1'b1;
        result_valid = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = ADDR_W'(slot_new >> ROW_LOG);
        wr_en        = 1'b0;
        wr_addr      = ADDR_W'(slot_reg >> ROW_LOG);
        wr_data      = rd_data_reg;
        case (state_reg)
            hkpf_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            hkpf_pkg::ST_IDLE:
            begin
                busy  = 1'b0;
                rd_en = key_done;
            end
            hkpf_pkg::ST_REPLY:
            begin
                result_valid     = 1'b1;
                wr_en            = (req_reg == hkpf_pkg::REQ_INSERT);
                wr_data[bit_sel] = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign slot_index    = hkpf_pkg::SLOT_INDEX_W'(slot_reg);
    assign slot_occupied = rd_data_reg[bit_sel];
    assign was_insert    = (req_reg == hkpf_pkg::REQ_INSERT);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            occ_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= occ_mem[rd_addr];
        end
    end

    // slot and request held for the reply cycle
    always_ff @(posedge clk)
    begin
        if (key_done)
        begin
            slot_reg <= slot_new;
            req_reg  <= req_type;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hkpf_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            hash_reg       <= SEED;
            bytes_seen_reg <= 8'd0;
            key_length_reg <= hkpf_pkg::KEY_LENGTH_RESET;
            table_bits_reg <= hkpf_pkg::TABLE_BITS_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            hash_reg       <= hash_next;
            bytes_seen_reg <= bytes_seen_next;
            if (state_reg == hkpf_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hkpf_pkg::CFG_KEY_LENGTH:
                    begin
                        key_length_reg <= cfg_data[hkpf_pkg::KEY_LENGTH_W-1:0];
                    end
                    hkpf_pkg::CFG_TABLE_BITS:
                    begin
                        table_bits_reg <= cfg_data[hkpf_pkg::TABLE_BITS_W-1:0];
                    end
                    default:
                    begin
                        key_length_reg <= key_length_reg;
                    end
                endcase
            end
        end
    end

    // a completed key gives its result in the next cycle
    a_key_reply: assert property (@(posedge clk) disable iff (!rst_n)
        key_done |=> result_valid)
        else $error("completed key did not produce a result");

    // the hash restarts from the seed after every key
    a_hash_restart: assert property (@(posedge clk) disable iff (!rst_n)
        key_done |=> (hash_reg == SEED && bytes_seen_reg == 8'd0))
        else $error("hash not restarted after key");

    // no read during the row write-back, and results never come back to back
    a_reply_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!rd_en ##1 !result_valid))
        else $error("reply overlapped a memory read");

    // no byte is taken while the memory is being cleared
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hkpf_pkg::ST_CLEAR) |-> (busy && !accept))
        else $error("byte accepted during clearing");

endmodule
